/* rtl/oosr_pkg.sv */
// ----------------------------------------------------------------------------
// oosr_pkg
// Shared types, sizes and the fill-percent table of the sample ring.
// ----------------------------------------------------------------------------
package oosr_pkg;

  // Ring geometry
  localparam int DEPTH      = 32;
  localparam int RESULT_CAP = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = $clog2(RESULT_CAP + 1);

  // Field widths
  localparam int TEMP_W  = 16;
  localparam int TIME_W  = 64;
  localparam int FILL_W  = 7;
  localparam int ENTRY_W = TEMP_W + TIME_W;

  // Operation codes; the spare code is ignored by the ring
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_DRAIN = 2'd1,
    OP_QUERY = 2'd2,
    OP_SPARE = 2'd3
  } op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  // Request word
  typedef struct packed {
    logic [1:0]               operation;
    logic signed [TEMP_W-1:0] sample_temp;
    logic [TIME_W-1:0]        sample_time;
    logic [FILL_W-1:0]        drain_limit;
  } req_t;

  // Result word
  typedef struct packed {
    logic                     entry_valid;
    logic signed [TEMP_W-1:0] entry_temp;
    logic [TIME_W-1:0]        entry_time;
    logic                     last_item;
    logic [FILL_W-1:0]        fill_count;
    logic [FILL_W-1:0]        fill_percent;
  } rsp_t;

  // Percent of fill for every count 0..DEPTH, floored
  typedef logic [DEPTH:0][FILL_W-1:0] pct_table_t;

  function automatic pct_table_t build_pct_table();
    pct_table_t tbl;
    for (int i = 0; i <= DEPTH; i++) begin
      tbl[i] = FILL_W'((i * 100) / DEPTH);
    end
    return tbl;
  endfunction

  localparam pct_table_t PCT_TABLE = build_pct_table();

endpackage

/* rtl/oosr_ram.sv */
// ----------------------------------------------------------------------------
// oosr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module oosr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/overwrite_oldest_sample_ring_unit.sv */
// A push stores its sample and gives no result; a query or an empty drain gives
// its result in the cycle after acceptance. A drain holds busy_o while it reads
// its samples and gives one sample per cycle, each through the registered RAM read.
// The single read port of the sample RAM sets the drain rate of one per cycle.
// Reset clears the pointers and the full mark; RAM contents stay undefined.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// overwrite_oldest_sample_ring_unit
// Ring of timestamped temperature samples that drops the oldest when full.
// ----------------------------------------------------------------------------
module overwrite_oldest_sample_ring_unit
  import oosr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic valid_o,
  output rsp_t rsp_o
);

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic              full_q, full_d;
  logic [CAP_W-1:0]  left_q, left_d;

  logic              out_vld_q, out_vld_d;
  logic              out_ent_q, out_ent_d;
  logic              out_last_q, out_last_d;
  logic [FILL_W-1:0] out_cnt_q, out_cnt_d;
  logic [FILL_W-1:0] out_pct_q, out_pct_d;

  logic              accept;
  logic [CNT_W-1:0]  held;
  logic [FILL_W-1:0] held_ext;
  logic [FILL_W-1:0] take;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic              ram_we;
  logic              ram_re;
  logic [ENTRY_W-1:0] ram_rdata;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Count unread samples
  always_comb begin
    if (full_q) begin
      held = CNT_W'(DEPTH);
    end else if (wr_ptr_q >= rd_ptr_q) begin
      held = CNT_W'(wr_ptr_q - rd_ptr_q);
    end else begin
      held = CNT_W'(DEPTH) - CNT_W'(rd_ptr_q) + CNT_W'(wr_ptr_q);
    end
  end

  assign held_ext = FILL_W'(held);

  // Samples a drain returns: min of limit, fill and result cap
  always_comb begin
    take = (req_i.drain_limit < held_ext) ? req_i.drain_limit : held_ext;
    if (take > FILL_W'(RESULT_CAP)) begin
      take = FILL_W'(RESULT_CAP);
    end
  end

  // Pointer wrap
  assign wr_ptr_nxt = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

  assign ram_we = accept && (req_i.operation == OP_PUSH);
  assign ram_re = (state_q == ST_DRAIN);

  // Control and result sequencing
  always_comb begin
    state_d    = state_q;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    full_d     = full_q;
    left_d     = left_q;
    out_vld_d  = 1'b0;
    out_ent_d  = 1'b0;
    out_last_d = 1'b0;
    out_cnt_d  = '0;
    out_pct_d  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.operation)
            OP_PUSH: begin
              // store at write pointer, drop oldest when full
              wr_ptr_d = wr_ptr_nxt;
              if (full_q) begin
                rd_ptr_d = wr_ptr_nxt;
              end else if (wr_ptr_nxt == rd_ptr_q) begin
                full_d = 1'b1;
              end
            end
            OP_DRAIN: begin
              if (take == '0) begin
                // empty drain: one invalid word, state kept
                out_vld_d  = 1'b1;
                out_last_d = 1'b1;
              end else begin
                left_d  = CAP_W'(take);
                full_d  = 1'b0;
                state_d = ST_DRAIN;
              end
            end
            OP_QUERY: begin
              out_vld_d  = 1'b1;
              out_last_d = 1'b1;
              out_cnt_d  = held_ext;
              out_pct_d  = PCT_TABLE[held];
            end
            default: begin
              // unused code: ignore
            end
          endcase
        end
      end
      ST_DRAIN: begin
        // read one sample per cycle, advance read pointer
        rd_ptr_d   = rd_ptr_nxt;
        left_d     = left_q - 1'b1;
        out_vld_d  = 1'b1;
        out_ent_d  = 1'b1;
        out_last_d = (left_q == CAP_W'(1));
        if (left_q == CAP_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      full_q     <= 1'b0;
      left_q     <= '0;
      out_vld_q  <= 1'b0;
      out_ent_q  <= 1'b0;
      out_last_q <= 1'b0;
      out_cnt_q  <= '0;
      out_pct_q  <= '0;
    end else begin
      state_q    <= state_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      full_q     <= full_d;
      left_q     <= left_d;
      out_vld_q  <= out_vld_d;
      out_ent_q  <= out_ent_d;
      out_last_q <= out_last_d;
      out_cnt_q  <= out_cnt_d;
      out_pct_q  <= out_pct_d;
    end
  end

  // Sample store: temperature and timestamp side by side
  oosr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i ({req_i.sample_temp, req_i.sample_time}),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // Drive the result word; sample fields only on drained entries
  assign valid_o            = out_vld_q;
  assign rsp_o.entry_valid  = out_ent_q;
  assign rsp_o.entry_temp   = out_ent_q ? ram_rdata[ENTRY_W-1:TIME_W] : '0;
  assign rsp_o.entry_time   = out_ent_q ? ram_rdata[TIME_W-1:0] : '0;
  assign rsp_o.last_item    = out_last_q;
  assign rsp_o.fill_count   = out_cnt_q;
  assign rsp_o.fill_percent = out_pct_q;

endmodule
